FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Entry and command structs, operation and status codes, default depth.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Default number of cells in the chain
  localparam int SPQ_DEPTH = 16;

  // Field widths fixed by the interface
  localparam int DATA_W = 32;
  localparam int PRIO_W = 16;
  localparam int OCC_W  = 5;

  // Operation codes carried in the kind field
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // Status codes reported with every result beat
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One stored entry
  typedef struct packed {
    logic                     vld;
    logic signed [DATA_W-1:0] data;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic signed [DATA_W-1:0] data;
    logic signed [PRIO_W-1:0] prio;
  } cell_cmd_t;

endpackage

FILE: rtl/spq_in_if.sv
// ----------------------------------------------------------------------------
// spq_in_if: request channel of the sorted priority queue
// Valid/ready handshake carrying one enqueue or dequeue request per beat.
// ----------------------------------------------------------------------------
interface spq_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] data;
  logic signed [15:0] priority_req;

  modport source (output valid, kind, data, priority_req, input ready);
  modport sink   (input valid, kind, data, priority_req, output ready);
endinterface

FILE: rtl/spq_out_if.sv
// ----------------------------------------------------------------------------
// spq_out_if: result channel of the sorted priority queue
// Valid/ready handshake carrying status and the front-of-queue view.
// ----------------------------------------------------------------------------
interface spq_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               front_valid;
  logic signed [31:0] front_data;
  logic [4:0]         occupancy;

  modport source (output valid, status, front_valid, front_data, occupancy, input ready);
  modport sink   (input valid, status, front_valid, front_data, occupancy, output ready);
endinterface

FILE: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one storage cell of the sorted chain
// Holds one entry; on enqueue it keeps, takes the new entry or takes its left
// neighbor; on dequeue it takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::cell_cmd_t cmd,
  input  logic               prev_stay,
  input  spq_pkg::entry_t    prev_entry,
  input  spq_pkg::entry_t    next_entry,
  output logic               stay,
  output spq_pkg::entry_t    entry,
  output spq_pkg::entry_t    entry_nxt
);
  import spq_pkg::*;

  entry_t entry_r;

  // Entry keeps its place when it is ahead of the new one (ties stay ahead)
  assign stay  = entry_r.vld && (entry_r.prio <= cmd.prio);
  assign entry = entry_r;

  // Next-entry selection
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.enq) begin
      if (stay) begin
        entry_nxt = entry_r;
      end else if (prev_stay) begin
        entry_nxt.vld  = 1'b1;
        entry_nxt.data = cmd.data;
        entry_nxt.prio = cmd.prio;
      end else begin
        entry_nxt = prev_entry;
      end
    end else if (cmd.deq) begin
      entry_nxt = next_entry;
    end
  end

  // Entry register: valid bit cleared on reset, payload not reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.vld <= 1'b0;
    end else begin
      entry_r.vld <= entry_nxt.vld;
    end
    entry_r.data <= entry_nxt.data;
    entry_r.prio <= entry_nxt.prio;
  end

endmodule

FILE: rtl/sorted_priority_queue_top.sv
// Result: a result beat is registered and appears in the cycle after its request
// beat is accepted. Throughput: one request per cycle, but a stalled result
// register holds back new requests until it is taken. Every cell compares and
// shifts in parallel, so an insert or removal takes effect at the accepting edge.
// Reset: synchronous, active low; clears the count, all cell valid bits and the
// result valid flag, leaving an empty queue. No clearing pass is needed.
// ----------------------------------------------------------------------------
// sorted_priority_queue_top: bounded priority queue as a sorted cell chain
// Enqueue inserts behind entries of lower or equal priority; dequeue drops
// the front. Each request yields one status and front-of-queue beat.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
  parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  // Chain wiring
  entry_t    cell_q   [DEPTH];
  entry_t    cell_nxt [DEPTH];
  logic      cell_stay[DEPTH];
  cell_cmd_t cmd;

  // Occupancy and result register
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r;
  status_t           status_r, status_nxt;
  logic              front_valid_r;
  logic [DATA_W-1:0] front_data_r, front_data_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [CNT_W+OCC_W-1:0] cnt_ext;

  logic accept, full, empty;

  // Handshake: the result register parts the two sides
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(DEPTH));
  assign empty       = (count_r == '0);

  // Command broadcast to the cells
  always_comb begin
    cmd.enq  = accept && (in_ch.kind == KIND_ENQ) && !full;
    cmd.deq  = accept && (in_ch.kind == KIND_DEQ) && !empty;
    cmd.data = in_ch.data;
    cmd.prio = in_ch.priority_req;
  end

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   prev_stay;
    entry_t prev_entry;
    entry_t next_entry;
    if (i == 0) begin : g_head
      assign prev_stay  = 1'b1;
      assign prev_entry = '0;
    end else begin : g_mid
      assign prev_stay  = cell_stay[i-1];
      assign prev_entry = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_body
      assign next_entry = cell_q[i+1];
    end
    spq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .prev_stay  (prev_stay),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .stay       (cell_stay[i]),
      .entry      (cell_q[i]),
      .entry_nxt  (cell_nxt[i])
    );
  end

  // Count and result values after this beat
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    if (in_ch.kind == KIND_ENQ) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end else begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        count_nxt = count_r - 1'b1;
      end
    end
    front_data_nxt = cell_nxt[0].vld ? cell_nxt[0].data : '0;
    cnt_ext        = {{OCC_W{1'b0}}, count_nxt};
    occ_nxt        = cnt_ext[OCC_W-1:0];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r      <= status_nxt;
      front_valid_r <= (count_nxt != '0);
      front_data_r  <= front_data_nxt;
      occ_r         <= occ_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.front_valid = front_valid_r;
  assign out_ch.front_data  = front_data_r;
  assign out_ch.occupancy   = occ_r;

endmodule

FILE: tb/sv/spq_order_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_order_checker: order and peek checker for the sorted priority queue
// Watches both channels, keeps a sorted copy of the queue contents, works out
// the status and front view for each accepted request and compares it with
// the result beats in order. Reports the number of failures to the top.
// ----------------------------------------------------------------------------
module spq_order_checker (
  input  logic clk,
  input  logic rst_n,
  spq_in_if    in_mon,
  spq_out_if   out_mon,
  output int   fail_count,
  output int   outstanding
);
  import spq_pkg::*;

  // One predicted result beat
  typedef struct {
    status_t                  status;
    logic                     front_valid;
    logic signed [DATA_W-1:0] front_data;
    logic [OCC_W-1:0]         occupancy;
  } peek_t;

  // Sorted shadow of the queue, index 0 is the front
  logic signed [DATA_W-1:0] held_data [SPQ_DEPTH];
  logic signed [PRIO_W-1:0] held_prio [SPQ_DEPTH];
  int                       held_count;

  peek_t expected_peeks [$];

  // Apply one request to the shadow queue and report the resulting peek
  task automatic apply_request(input logic kind, input logic signed [DATA_W-1:0] data,
                               input logic signed [PRIO_W-1:0] prio, output peek_t res);
    int slot;
    res.status = ST_OK;
    if (kind == KIND_ENQ) begin
      if (held_count >= SPQ_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // insert behind every entry of lower or equal priority
        slot = 0;
        while (slot < held_count && held_prio[slot] <= prio) slot++;
        for (int i = held_count; i > slot; i--) begin
          held_data[i] = held_data[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_data[slot] = data;
        held_prio[slot] = prio;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        for (int i = 1; i < held_count; i++) begin
          held_data[i-1] = held_data[i];
          held_prio[i-1] = held_prio[i];
        end
        held_count--;
      end
    end
    res.front_valid = (held_count != 0);
    res.front_data  = (held_count != 0) ? held_data[0] : '0;
    res.occupancy   = OCC_W'(held_count);
  endtask

  // Compare result beats first, then record the request of the same edge
  always @(posedge clk) begin
    peek_t exp_peek;
    peek_t new_peek;
    if (!rst_n) begin
      held_count = 0;
      expected_peeks.delete();
      fail_count  = 0;
      outstanding = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_peeks.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected result beat: status=%0d fv=%0d data=%0h occ=%0d",
                     $realtime, out_mon.status, out_mon.front_valid, out_mon.front_data,
                     out_mon.occupancy);
        end else begin
          exp_peek = expected_peeks.pop_front();
          if (out_mon.status !== exp_peek.status ||
              out_mon.front_valid !== exp_peek.front_valid ||
              out_mon.front_data !== exp_peek.front_data ||
              out_mon.occupancy !== exp_peek.occupancy) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] result mismatch: exp status=%0d fv=%0d data=%0h occ=%0d",
                       $realtime, exp_peek.status, exp_peek.front_valid,
                       exp_peek.front_data, exp_peek.occupancy,
                       " | got status=%0d fv=%0d data=%0h occ=%0d", out_mon.status,
                       out_mon.front_valid, out_mon.front_data, out_mon.occupancy);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        apply_request(in_mon.kind, in_mon.data, in_mon.priority_req, new_peek);
        expected_peeks.push_back(new_peek);
      end
      outstanding = expected_peeks.size();
    end
  end

endmodule

FILE: tb/sv/sorted_priority_queue_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_tb: testbench top for the sorted priority queue
// Drives a short directed sequence (empty and extreme cases, priority ties)
// and then random fill, drain and mixed bursts with random gaps on both
// channels. Checking is done by spq_order_checker; this module gives verdict.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top_tb;
  import spq_pkg::*;

  localparam int ITEM_TARGET = 950;

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIX} burst_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  bit   tx_quiet;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  spq_order_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #(5_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  // Idle cycles before a beat; none during quiet stretches
  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : int'($urandom_range(0, 16));
  endfunction

  // Priorities: a narrow band to force ties, plus extremes and full range
  function automatic logic signed [PRIO_W-1:0] draw_prio();
    int v;
    case ($urandom_range(0, 9))
      0:       v = -32768;
      1:       v = 32767;
      2, 3, 4, 5: v = int'($urandom_range(0, 6)) - 3;
      default: v = int'($urandom);
    endcase
    return v[PRIO_W-1:0];
  endfunction

  // One request beat; called and returns at a falling edge
  task automatic send_request(input logic kind, input logic signed [DATA_W-1:0] data,
                              input logic signed [PRIO_W-1:0] prio);
    int gap;
    gap = draw_wait(tx_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.data         <= data;
    in_ch.priority_req <= prio;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Dequeue with junk in the ignored fields
  task automatic send_deq();
    send_request(KIND_DEQ, $urandom, PRIO_W'($urandom));
  endtask

  // Hold off until every outstanding result has been taken
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // Result side: random stalls with quiet stretches
  initial begin
    int stall;
    int taken;
    out_ch.ready = 1'b0;
    taken = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = draw_wait(((taken / 40) % 3) == 2);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
      @(negedge clk);
    end
  end

  // Request side and verdict
  initial begin
    int     sent;
    int     len;
    int     enq_pct;
    int     burst_idx;
    burst_t burst;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_ENQ;
    in_ch.data         = '0;
    in_ch.priority_req = '0;
    tx_quiet           = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: dequeue on empty, field extremes, ties, drain past empty
    send_request(KIND_DEQ, 32'sh8000_0000, 16'sh7fff);
    send_request(KIND_ENQ, 32'sh7fff_ffff, 16'sh7fff);
    send_request(KIND_ENQ, 32'sh8000_0000, 16'sh8000);
    send_request(KIND_ENQ, 32'sh0000_0000, 16'sh0000);
    send_request(KIND_ENQ, 32'shffff_ffff, 16'shffff);
    send_request(KIND_ENQ, 32'sh0000_0011, 16'sh0000);
    send_request(KIND_ENQ, 32'sh0000_0022, 16'sh0000);
    send_request(KIND_ENQ, 32'sh0000_0033, 16'sh7fff);
    send_request(KIND_ENQ, 32'sh0000_0044, 16'sh8000);
    repeat (9) send_deq();
    wait_drained();

    // Random bursts; the first one fills the queue past full
    sent      = 0;
    burst_idx = 0;
    while (sent < ITEM_TARGET) begin
      if (burst_idx == 0) begin
        burst   = BURST_FILL;
        len     = 20;
        enq_pct = 100;
      end else begin
        burst = burst_t'($urandom_range(0, 2));
        len   = $urandom_range(8, 40);
        case (burst)
          BURST_FILL:  enq_pct = 85;
          BURST_DRAIN: enq_pct = 15;
          default:     enq_pct = 50;
        endcase
      end
      tx_quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < len; n++) begin
        if ($urandom_range(0, 99) < enq_pct)
          send_request(KIND_ENQ, $urandom, draw_prio());
        else
          send_deq();
      end
      sent += len;
      if ($urandom_range(0, 3) == 0) wait_drained();
      burst_idx++;
    end

    // Drain and let the pipeline settle
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
